/* rtl/ntcb_pkg.sv */
// Shared types and constants for the NTC beta-equation temperature pipeline.
`default_nettype none
package ntcb_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CODE = 2'd1,
    ST_RES  = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FIXED  = 3'd0,
    REG_SERIES = 3'd1,
    REG_BETA   = 3'd2,
    REG_T1     = 3'd3,
    REG_R1     = 3'd4
  } reg_idx_e;

  // Status travelling with each beat; hi marks saturation at the top end
  typedef struct packed {
    logic    hi;
    status_e st;
  } tag_t;

  localparam int unsigned LOG_ITER = 16;          // fraction bits of log2
  localparam int unsigned LOG_W    = 22;          // 6 integer + 16 fraction bits
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [16:0] TEMP_MAX = 17'h1FFFF;

endpackage
`default_nettype wire

/* rtl/ntcb_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module ntcb_div
  import ntcb_pkg::*;
#(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire tag_t          tag_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] div_i,
  output logic               vld_o,
  output tag_t               tag_o,
  output logic [NW-1:0]      quo_o
);

  logic [NW-1:0]  vld_q;
  tag_t           tag_q [NW];
  logic [DW-1:0]  rem_q [NW];
  logic [NW-1:0]  num_q [NW];
  logic [DW-1:0]  div_q [NW];

  // Valid bits follow the data down the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_s;
    logic [NW-1:0] num_s;
    logic [DW-1:0] div_s;
    tag_t          tag_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_s = rem_i;
      assign num_s = num_i;
      assign div_s = div_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign num_s = num_q[k-1];
      assign div_s = div_q[k-1];
      assign tag_s = tag_q[k-1];
    end

    // shift in next numerator bit, subtract if it fits
    assign trial = {rem_s, num_s[NW-1]};
    assign diff  = trial - {1'b0, div_s};
    assign ge    = (trial >= {1'b0, div_s});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k] <= {num_s[NW-2:0], ge};
        div_q[k] <= div_s;
        tag_q[k] <= tag_s;
      end
    end
  end

  assign vld_o = vld_q[NW-1];
  assign tag_o = tag_q[NW-1];
  assign quo_o = num_q[NW-1];

endmodule
`default_nettype wire

/* rtl/ntcb_log2.sv */
// Two-lane pipelined base-2 logarithm in Q16 by repeated squaring.
`default_nettype none
module ntcb_log2
  import ntcb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire tag_t             tag_i,
  input  wire logic [62:0]      va_i,
  input  wire logic [62:0]      vb_i,
  output logic                  vld_o,
  output tag_t                  tag_o,
  output logic [LOG_W-1:0]      la_o,
  output logic [LOG_W-1:0]      lb_o
);

  localparam int unsigned NL = 2;
  localparam int unsigned NS = LOG_ITER + 2;

  // index of the top set bit, 0 for a zero word
  function automatic logic [5:0] top_bit(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic [NL-1:0][62:0] v_in;
  logic [NL-1:0][62:0] v0_q;
  logic [NL-1:0][5:0]  p0_q;
  logic [NL-1:0][30:0] m1_q;
  logic [NL-1:0][5:0]  p1_q;
  logic [30:0]         mi_q [LOG_ITER][NL];
  logic [15:0]         fi_q [LOG_ITER][NL];
  logic [5:0]          pi_q [LOG_ITER][NL];
  logic [NS-1:0]       vld_q;
  tag_t                tag_q [NS];

  assign v_in[0] = va_i;
  assign v_in[1] = vb_i;

  // valid and status run alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int j = 1; j < NS; j++) tag_q[j] <= tag_q[j-1];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [92:0] shifted;

    // leading-one search, then normalize mantissa to Q30
    assign shifted = {v0_q[l], 30'b0} >> p0_q[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v0_q[l] <= v_in[l];
        p0_q[l] <= top_bit(v_in[l]);
        m1_q[l] <= shifted[30:0];
        p1_q[l] <= p0_q[l];
      end
    end

    // one squaring per stage yields one fraction bit
    for (genvar k = 0; k < LOG_ITER; k++) begin : g_iter
      logic [30:0] m_s;
      logic [15:0] f_s;
      logic [5:0]  p_s;
      logic [61:0] sq;
      logic [31:0] sc;

      if (k == 0) begin : g_first
        assign m_s = m1_q[l];
        assign f_s = '0;
        assign p_s = p1_q[l];
      end else begin : g_next
        assign m_s = mi_q[k-1][l];
        assign f_s = fi_q[k-1][l];
        assign p_s = pi_q[k-1][l];
      end

      assign sq = m_s * m_s;
      assign sc = sq[61:30];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mi_q[k][l] <= sc[31] ? sc[31:1] : sc[30:0];
          fi_q[k][l] <= {f_s[14:0], sc[31]};
          pi_q[k][l] <= p_s;
        end
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign tag_o = tag_q[NS-1];
  assign la_o  = {pi_q[LOG_ITER-1][0], fi_q[LOG_ITER-1][0]};
  assign lb_o  = {pi_q[LOG_ITER-1][1], fi_q[LOG_ITER-1][1]};

endmodule
`default_nettype wire

/* rtl/ntc_beta_temperature.sv */
// Top level: NTC thermistor temperature by the beta equation, fully pipelined.
// Takes one converter code per cycle while the output is not stalled and returns one
// temperature beat per code, in 0.01 K. The pipeline holds the 63 one-bit stages of
// the resistance divider, the 18 stages of the logarithm unit and the 17 stages of
// the temperature divider; a stall at the output holds the whole pipeline.
// Configuration writes take effect at once; the user must make them only while the
// pipeline is empty, as the block itself does not enforce this.
`default_nettype none
module ntc_beta_temperature
  import ntcb_pkg::*;
#(
  parameter int unsigned ADC_FULL_SCALE = 8388607
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] adc_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      temp_centikelvin_o,
  output logic [1:0]       status_o
);

  localparam logic [22:0] FULL_C = 23'(ADC_FULL_SCALE);

  // configuration registers
  logic [23:0] fixed_q;
  logic [15:0] series_q;
  logic [15:0] beta_q;
  logic [15:0] t1_q;
  logic [23:0] r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q  <= 24'd10000;
      series_q <= 16'd0;
      beta_q   <= 16'd3950;
      t1_q     <= 16'd29815;
      r1_q     <= 24'd10000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FIXED:  fixed_q  <= cfg_wdata_i;
        REG_SERIES: series_q <= cfg_wdata_i[15:0];
        REG_BETA:   beta_q   <= cfg_wdata_i[15:0];
        REG_T1:     t1_q     <= cfg_wdata_i[15:0];
        REG_R1:     r1_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: move unless the output beat is waiting
  logic out_vld_q;
  logic en;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // S0: code checks
  tag_t        tag_in;
  logic        s0_vld_q;
  tag_t        s0_tag_q;
  logic [22:0] s0_code_q;
  logic [22:0] s0_diff_q;

  always_comb begin
    tag_in.hi = 1'b0;
    if (adc_code_i[23] || (adc_code_i == '0)) begin
      tag_in.st = ST_CODE;
    end else if (adc_code_i[22:0] >= FULL_C) begin
      tag_in.st = ST_RES;
    end else begin
      tag_in.st = ST_OK;
    end
  end

  // S1: numerator fixed * (full - code) in Q16
  logic        s1_vld_q;
  tag_t        s1_tag_q;
  logic [62:0] s1_num_q;
  logic [22:0] s1_code_q;
  logic [46:0] s1_prod;
  assign s1_prod = fixed_q * s0_diff_q;

  // S2 inputs from divider
  logic        d1_vld;
  tag_t        d1_tag;
  logic [62:0] d1_quo;
  logic [62:0] sq_ext;
  tag_t        s2_tag_d;
  logic        s2_vld_q;
  tag_t        s2_tag_q;
  logic [62:0] s2_r_q;

  // S3..S7
  logic             lg_vld;
  tag_t             lg_tag;
  logic [LOG_W-1:0] lg_a;
  logic [LOG_W-1:0] lg_b;
  logic [LOG_W:0]   dlog;
  logic [LOG_W-1:0] dmag;
  logic             s3_vld_q;
  tag_t             s3_tag_q;
  logic             s3_neg_q;
  logic [51:0]      s3_prod_q;
  logic [51:0]      s3_rnd;
  logic             s4_vld_q;
  tag_t             s4_tag_q;
  logic             s4_neg_q;
  logic [21:0]      s4_mag_q;
  logic [22:0]      s4_b100_q;
  logic             s5_vld_q;
  tag_t             s5_tag_q;
  logic             s5_neg_q;
  logic [37:0]      s5_lt_q;
  logic [38:0]      s5_num_q;
  logic [22:0]      s5_b100_q;
  logic signed [40:0] s6_base;
  logic signed [40:0] s6_lt;
  logic signed [40:0] s6_dd;
  logic             s6_pos;
  tag_t             s6_tag_d;
  logic             s6_vld_q;
  tag_t             s6_tag_q;
  logic [39:0]      s6_dd_q;
  logic [55:0]      s6_n_q;
  tag_t             s7_tag_d;
  logic             s7_vld_q;
  tag_t             s7_tag_q;
  logic [39:0]      s7_rem_q;
  logic [16:0]      s7_num_q;
  logic [39:0]      s7_dd_q;
  logic             d2_vld;
  tag_t             d2_tag;
  logic [16:0]      d2_quo;
  logic [16:0]      out_temp_q;
  status_e          out_st_q;

  // resistance not positive, then zero reference resistance
  assign sq_ext = {31'b0, series_q, 16'b0};
  always_comb begin
    s2_tag_d = d1_tag;
    if (d1_tag.st == ST_OK) begin
      if (d1_quo <= sq_ext) begin
        s2_tag_d.st = ST_RES;
      end else if (r1_q == '0) begin
        s2_tag_d.st = ST_SAT;
      end
    end
  end

  // log difference magnitude
  assign dlog = {1'b0, lg_b} - {1'b0, lg_a};
  assign dmag = dlog[LOG_W] ? LOG_W'(-dlog) : dlog[LOG_W-1:0];

  // round ln term to Q16
  assign s3_rnd = s3_prod_q + (52'd1 << 29);

  // denominator and rounded numerator
  assign s6_base = $signed({2'b0, s5_b100_q, 16'b0});
  assign s6_lt   = $signed({3'b0, s5_lt_q});
  assign s6_dd   = s5_neg_q ? (s6_base + s6_lt) : (s6_base - s6_lt);
  assign s6_pos  = !s6_dd[40] && (s6_dd != '0);
  always_comb begin
    s6_tag_d = s5_tag_q;
    if (s5_tag_q.st == ST_OK && !s6_pos) begin
      s6_tag_d.st = ST_SAT;
      s6_tag_d.hi = 1'b1;
    end
  end

  // quotient overflow check
  always_comb begin
    s7_tag_d = s6_tag_q;
    if (s6_tag_q.st == ST_OK && ({1'b0, s6_n_q} >= {s6_dd_q, 17'b0})) begin
      s7_tag_d.st = ST_SAT;
      s7_tag_d.hi = 1'b1;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= d1_vld;
      s3_vld_q  <= lg_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= d2_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_tag_q   <= tag_in;
      s0_code_q  <= adc_code_i[22:0];
      s0_diff_q  <= FULL_C - adc_code_i[22:0];
      s1_tag_q   <= s0_tag_q;
      s1_num_q   <= {s1_prod, 16'b0};
      s1_code_q  <= s0_code_q;
      s2_tag_q   <= s2_tag_d;
      s2_r_q     <= d1_quo - sq_ext;
      s3_tag_q   <= lg_tag;
      s3_neg_q   <= dlog[LOG_W];
      s3_prod_q  <= dmag * LN2_Q30;
      s4_tag_q   <= s3_tag_q;
      s4_neg_q   <= s3_neg_q;
      s4_mag_q   <= s3_rnd[51:30];
      s4_b100_q  <= beta_q * 7'd100;
      s5_tag_q   <= s4_tag_q;
      s5_neg_q   <= s4_neg_q;
      s5_lt_q    <= s4_mag_q * t1_q;
      s5_num_q   <= t1_q * s4_b100_q;
      s5_b100_q  <= s4_b100_q;
      s6_tag_q   <= s6_tag_d;
      s6_dd_q    <= s6_dd[39:0];
      s6_n_q     <= {1'b0, s5_num_q, 16'b0} + {17'b0, s6_dd[39:1]};
      s7_tag_q   <= s7_tag_d;
      s7_rem_q   <= {1'b0, s6_n_q[55:17]};
      s7_num_q   <= s6_n_q[16:0];
      s7_dd_q    <= s6_dd_q;
      out_st_q   <= d2_tag.st;
      if (d2_tag.st == ST_OK) begin
        out_temp_q <= d2_quo;
      end else if (d2_tag.st == ST_SAT && d2_tag.hi) begin
        out_temp_q <= TEMP_MAX;
      end else begin
        out_temp_q <= '0;
      end
    end
  end

  // resistance divider
  ntcb_div #(
    .NW(63),
    .DW(23)
  ) u_div_res (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s1_vld_q),
    .tag_i (s1_tag_q),
    .rem_i ('0),
    .num_i (s1_num_q),
    .div_i (s1_code_q),
    .vld_o (d1_vld),
    .tag_o (d1_tag),
    .quo_o (d1_quo)
  );

  // log2 of thermistor and reference resistance
  ntcb_log2 u_log (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s2_vld_q),
    .tag_i (s2_tag_q),
    .va_i  (s2_r_q),
    .vb_i  ({23'b0, r1_q, 16'b0}),
    .vld_o (lg_vld),
    .tag_o (lg_tag),
    .la_o  (lg_a),
    .lb_o  (lg_b)
  );

  // temperature divider, quotient known to fit 17 bits
  ntcb_div #(
    .NW(17),
    .DW(40)
  ) u_div_temp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s7_vld_q),
    .tag_i (s7_tag_q),
    .rem_i (s7_rem_q),
    .num_i (s7_num_q),
    .div_i (s7_dd_q),
    .vld_o (d2_vld),
    .tag_o (d2_tag),
    .quo_o (d2_quo)
  );

  assign out_valid_o        = out_vld_q;
  assign temp_centikelvin_o = out_temp_q;
  assign status_o           = out_st_q;

endmodule
`default_nettype wire
